// File: sv/sap_pkg.sv
// sap_pkg: sizes, status codes and shared types of the seat allocator
// no dependencies; compiled first
`default_nettype none
package sap_pkg;

   // pool and queue sizes
   localparam int MAX_SLOTS   = 64;
   localparam int QUEUE_DEPTH = 64;
   localparam int ID_BITS     = 16;

   // field widths of the channels
   localparam int OP_W        = 1;
   localparam int SLOT_NUM_W  = 7;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 7;

   // derived widths
   localparam int SLOT_IDX_W  = $clog2(MAX_SLOTS);
   localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W       = (CNT_W > SLOT_NUM_W) ? CNT_W : SLOT_NUM_W;
   localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // free-slot search tree: groups of eight slots
   localparam int GRP_SIZE    = 8;
   localparam int GRP_W       = $clog2(GRP_SIZE);
   localparam int NGRP        = (MAX_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
   localparam int PAD_IDX_W   = $clog2(NGRP * GRP_SIZE);

   // opcodes
   localparam logic [OP_W-1:0] OP_BOOK   = 1'b0;
   localparam logic [OP_W-1:0] OP_CANCEL = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_BOOKED      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_QUEUED      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RELEASED    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_REASSIGNED  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_INVALID     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_ALREADYFREE = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_QUEUEFULL   = 3'd6;

   // answer of the free-slot search
   typedef struct packed {
      logic                  found;
      logic [SLOT_IDX_W-1:0] index;
   } search_type;

endpackage : sap_pkg
`default_nettype wire

// File: sv/sap_channels.sv
// sap_channels: valid/ready channel interfaces for requests, results and the csr write
// depends on sap_pkg
`default_nettype none

// request channel
interface sap_req_if
   import sap_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       opcode;
   logic [ID_BITS-1:0]    requester_id;
   logic [SLOT_NUM_W-1:0] target_slot;

   modport source (output valid, output opcode, output requester_id,
                   output target_slot, input ready);
   modport sink   (input valid, input opcode, input requester_id,
                   input target_slot, output ready);
endinterface : sap_req_if

// result channel
interface sap_rsp_if
   import sap_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [SLOT_NUM_W-1:0] slot_number;
   logic [ID_BITS-1:0]    released_id;
   logic [ID_BITS-1:0]    assigned_id;
   logic [COUNT_W-1:0]    waiting_count;

   modport source (output valid, output status, output slot_number,
                   output released_id, output assigned_id,
                   output waiting_count, input ready);
   modport sink   (input valid, input status, input slot_number,
                   input released_id, input assigned_id,
                   input waiting_count, output ready);
endinterface : sap_rsp_if

// configuration write channel
interface sap_csr_if
   import sap_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [SLOT_NUM_W-1:0] slots_in_use;

   modport source (output valid, output slots_in_use, input ready);
   modport sink   (input valid, input slots_in_use, output ready);
endinterface : sap_csr_if

`default_nettype wire

// File: sv/sap_ram.sv
// sap_ram: generic one-write one-read synchronous ram, registered read data
// no dependencies
`default_nettype none
module sap_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : sap_ram
`default_nettype wire

// File: sv/sap_search.sv
// sap_search: two-level lowest-free-slot search, group encoders registered
// depends on sap_pkg
`default_nettype none
module sap_search
   import sap_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 load,
   input  wire logic [MAX_SLOTS-1:0] free_vec,
   output      search_type           result
);

   logic [NGRP*GRP_SIZE-1:0] pad_vec;
   logic [NGRP-1:0]          grp_any_in;
   logic [NGRP-1:0]          grp_any_ff;
   logic [GRP_W-1:0]         grp_idx_in [NGRP];
   logic [GRP_W-1:0]         grp_idx_ff [NGRP];
   logic [PAD_IDX_W-1:0]     idx_wide;

   // first level: lowest free slot inside each group
   always_comb begin
      pad_vec = '0;
      pad_vec[MAX_SLOTS-1:0] = free_vec;
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int k = GRP_SIZE - 1; k >= 0; k--) begin
            if (pad_vec[g*GRP_SIZE + k]) begin
               grp_any_in[g] = 1'b1;
               grp_idx_in[g] = GRP_W'(k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_any_ff <= grp_any_in;
         grp_idx_ff <= grp_idx_in;
      end
   end

   // second level: lowest group with a free slot
   always_comb begin
      result.found = 1'b0;
      idx_wide     = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            result.found = 1'b1;
            idx_wide     = PAD_IDX_W'(g * GRP_SIZE) | PAD_IDX_W'(grp_idx_ff[g]);
         end
      end
      result.index = SLOT_IDX_W'(idx_wide);
   end

endmodule : sap_search
`default_nettype wire

// File: sv/seat_allocator_with_waitlist_core.sv
// seat_allocator_with_waitlist_core: slot pool with first-free booking and a fifo waitlist
// depends on sap_pkg, sap_channels, sap_ram, sap_search
//
//   channel | dir | transfer when      | carries
//   req     | in  | valid & ready      | opcode, requester_id, target_slot
//   rsp     | out | valid & ready      | status, slot_number, released_id, assigned_id,
//           |     |                    | waiting_count
//   csr     | in  | valid & ready      | slots_in_use (ready always high)
//
// a request is accepted, then executed: the accept cycle reads the owner and waitlist rams
// and registers the group level of the free-slot search; the execute cycle decides,
// writes the owner ram or the waitlist ram as needed and loads the result register.
// execute waits while an earlier result is still held; the next request is taken
// once execute has written back, so one request is in flight at a time.
// reset clears slot taken bits, queue pointers and count, sets slots_in_use to 64.
`default_nettype none
module seat_allocator_with_waitlist_core
   import sap_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sap_req_if.sink   req_if,
   sap_rsp_if.source rsp_if,
   sap_csr_if.sink   csr_if
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                  state_ff, state_in;
   logic [SLOT_NUM_W-1:0] slots_ff;
   logic [MAX_SLOTS-1:0]  taken_ff, taken_in;
   logic [Q_IDX_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [Q_CNT_W-1:0]    fill_ff, fill_in;

   logic [OP_W-1:0]       op_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [SLOT_NUM_W-1:0] target_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_NUM_W-1:0] slot_num_ff, slot_num_in;
   logic [ID_BITS-1:0]    rel_id_ff, rel_id_in, asg_id_ff, asg_id_in;
   logic [COUNT_W-1:0]    wcount_ff, wcount_in;

   logic                  req_fire, exec_done;
   logic [CNT_W-1:0]      active_n;
   logic [MAX_SLOTS-1:0]  free_vec;
   search_type            search;
   logic [SLOT_IDX_W-1:0] req_idx, tgt_idx;
   logic                  tgt_invalid;

   logic                  own_we;
   logic [SLOT_IDX_W-1:0] own_waddr;
   logic [ID_BITS-1:0]    own_wdata, own_rdata, q_rdata;
   logic                  q_we;

   // handshakes
   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_fire     = req_if.valid && req_if.ready;
   assign exec_done    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_if.ready);

   // slot count capped at pool size
   always_comb begin
      if (CMP_W'(slots_ff) > CMP_W'(MAX_SLOTS)) begin
         active_n = CNT_W'(MAX_SLOTS);
      end else begin
         active_n = CNT_W'(slots_ff);
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
         free_vec[i] = !taken_ff[i] && (CMP_W'(i) < CMP_W'(active_n));
      end
   end

   // ram addresses from the incoming and the held request
   assign req_idx     = SLOT_IDX_W'(req_if.target_slot - SLOT_NUM_W'(1));
   assign tgt_idx     = SLOT_IDX_W'(target_ff - SLOT_NUM_W'(1));
   assign tgt_invalid = (target_ff == '0) || (CMP_W'(target_ff) > CMP_W'(active_n));

   sap_search u_search (
      .clock    (clock),
      .load     (req_fire),
      .free_vec (free_vec),
      .result   (search)
   );

   sap_ram #(.DEPTH(MAX_SLOTS), .WIDTH(ID_BITS)) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data (own_wdata),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (own_rdata)
   );

   sap_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_BITS)) u_wait_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff),
      .wr_data (id_ff),
      .rd_en   (req_fire),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   // execute: decide the outcome and the write-back
   always_comb begin
      state_in     = state_ff;
      taken_in     = taken_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      own_we       = 1'b0;
      own_waddr    = tgt_idx;
      own_wdata    = q_rdata;
      q_we         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      slot_num_in  = slot_num_ff;
      rel_id_in    = rel_id_ff;
      asg_id_in    = asg_id_ff;
      wcount_in    = wcount_ff;

      if (req_fire) begin
         state_in = ST_EXEC;
      end

      if (exec_done) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         status_in    = STAT_INVALID;
         slot_num_in  = '0;
         rel_id_in    = '0;
         asg_id_in    = '0;
         if (op_ff == OP_BOOK) begin
            if (search.found) begin
               taken_in[search.index] = 1'b1;
               own_we      = 1'b1;
               own_waddr   = search.index;
               own_wdata   = id_ff;
               status_in   = STAT_BOOKED;
               slot_num_in = SLOT_NUM_W'(search.index) + SLOT_NUM_W'(1);
               asg_id_in   = id_ff;
            end else if (fill_ff == Q_CNT_W'(QUEUE_DEPTH)) begin
               status_in = STAT_QUEUEFULL;
            end else begin
               q_we      = 1'b1;
               tail_in   = (tail_ff == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               fill_in   = fill_ff + 1'b1;
               status_in = STAT_QUEUED;
            end
         end else if (tgt_invalid) begin
            status_in = STAT_INVALID;
         end else if (!taken_ff[tgt_idx]) begin
            status_in = STAT_ALREADYFREE;
         end else begin
            slot_num_in = target_ff;
            rel_id_in   = own_rdata;
            if (fill_ff != '0) begin
               // head of the waitlist takes the slot over
               own_we    = 1'b1;
               head_in   = (head_ff == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               fill_in   = fill_ff - 1'b1;
               status_in = STAT_REASSIGNED;
               asg_id_in = q_rdata;
            end else begin
               taken_in[tgt_idx] = 1'b0;
               status_in = STAT_RELEASED;
            end
         end
         wcount_in = COUNT_W'(fill_in);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slots_ff     <= SLOT_NUM_W'(64);
         taken_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taken_ff     <= taken_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            slots_ff <= csr_if.slots_in_use;
         end
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_if.opcode;
         id_ff     <= req_if.requester_id;
         target_ff <= req_if.target_slot;
      end
      status_ff   <= status_in;
      slot_num_ff <= slot_num_in;
      rel_id_ff   <= rel_id_in;
      asg_id_ff   <= asg_id_in;
      wcount_ff   <= wcount_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.slot_number   = slot_num_ff;
   assign rsp_if.released_id   = rel_id_ff;
   assign rsp_if.assigned_id   = asg_id_ff;
   assign rsp_if.waiting_count = wcount_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= Q_CNT_W'(QUEUE_DEPTH))
      else $error("waitlist count above depth");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      exec_done |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("execute finished without a result");

   a_reassign_pop: assert property (@(posedge clock) disable iff (reset)
      exec_done && (op_ff == OP_CANCEL) && !tgt_invalid && taken_ff[tgt_idx]
         && (fill_ff != '0)
      |=> (fill_ff == $past(fill_ff) - 1'b1) && (status_ff == STAT_REASSIGNED))
      else $error("reassignment did not pop the waitlist");

   a_queue_only_full: assert property (@(posedge clock) disable iff (reset)
      q_we |-> !search.found && (fill_ff != Q_CNT_W'(QUEUE_DEPTH)))
      else $error("waitlist written while a slot was free or queue full");

endmodule : seat_allocator_with_waitlist_core
`default_nettype wire
